// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sorted timer queue modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define STQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define STQ_NEVER(label, cond, msg) \
  `STQ_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/stq_pkg.sv =====
// Package: sizes, result codes and controller/datapath interface types
`timescale 1ns / 1ps

package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  localparam int DL_W    = 32;
  localparam int TAG_W   = 16;
  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_POPPED   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef struct packed {
    logic              insert_en;
    logic              pop_en;
    logic              load_res;
    logic [STAT_W-1:0] res_code;
  } stq_cmd_t;

  typedef struct packed {
    logic full;
    logic head_due;
  } stq_sts_t;

endpackage

// ===== hdl/stq_ctrl.sv =====
// Controller: input handshake, request decode and result valid state
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  output logic              out_valid,
  input  logic              out_stall,
  input  stq_pkg::stq_sts_t sts,
  output stq_pkg::stq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign out_valid = (state_r == S_HOLD);
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd.insert_en = 1'b0;
    cmd.pop_en    = 1'b0;
    cmd.load_res  = accept;
    cmd.res_code  = stq_pkg::ST_NONE;
    case (in_req_type)
      stq_pkg::REQ_INSERT: begin
        if (sts.full) begin
          cmd.res_code = stq_pkg::ST_FULL;
        end else begin
          cmd.insert_en = accept;
          cmd.res_code  = stq_pkg::ST_INSERTED;
        end
      end
      stq_pkg::REQ_POP: begin
        if (sts.head_due) begin
          cmd.pop_en   = accept;
          cmd.res_code = stq_pkg::ST_POPPED;
        end
      end
      default: cmd.res_code = stq_pkg::ST_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_HOLD;
      S_HOLD: if (!out_stall && !accept) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `STQ_NEVER(a_ins_pop_excl, cmd.insert_en && cmd.pop_en, "insert and pop together")
  `STQ_NEVER(a_ins_when_full, cmd.insert_en && sts.full, "insert into full queue")
  `STQ_ASSERT(a_acc_gives_res, accept |=> out_valid, "accepted item left no result")

endmodule

// ===== hdl/stq_dp.sv =====
// Datapath: chain of sorted timer cells, entry count and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stq_pkg::stq_cmd_t              cmd,
  output stq_pkg::stq_sts_t              sts,
  input  logic [stq_pkg::DL_W-1:0]       in_deadline,
  input  logic [stq_pkg::TAG_W-1:0]      in_timer_tag,
  input  logic [stq_pkg::DL_W-1:0]       in_now_time,
  output logic [stq_pkg::STAT_W-1:0]     out_status,
  output logic [stq_pkg::DL_W-1:0]       out_expired_deadline,
  output logic [stq_pkg::TAG_W-1:0]      out_expired_tag
);

  localparam int D = stq_pkg::QUEUE_DEPTH;

  logic [stq_pkg::DL_W-1:0]     dl_r  [D];
  logic [stq_pkg::TAG_KEEP-1:0] tag_r [D];
  logic [stq_pkg::CNT_W-1:0]    cnt_r;
  logic [D-1:0]                 keep;
  logic [stq_pkg::TAG_KEEP-1:0] new_tag;

  logic [stq_pkg::STAT_W-1:0]   res_status_r;
  logic [stq_pkg::DL_W-1:0]     res_dl_r;
  logic [stq_pkg::TAG_W-1:0]    res_tag_r;

  assign new_tag      = in_timer_tag[stq_pkg::TAG_KEEP-1:0];
  assign sts.full     = (cnt_r == stq_pkg::CNT_W'(D));
  assign sts.head_due = (cnt_r != '0) && (dl_r[0] <= in_now_time);

  // keep: valid cell whose deadline is not later than the new one
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign keep[i] = (cnt_r > stq_pkg::CNT_W'(i)) && (dl_r[i] <= in_deadline);

    always_ff @(posedge clk) begin
      if (cmd.insert_en && !keep[i]) begin
        if (i == 0) begin
          dl_r[i]  <= in_deadline;
          tag_r[i] <= new_tag;
        end else if (keep[(i == 0) ? 0 : i-1]) begin
          dl_r[i]  <= in_deadline;
          tag_r[i] <= new_tag;
        end else begin
          dl_r[i]  <= dl_r[(i == 0) ? 0 : i-1];
          tag_r[i] <= tag_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.pop_en && (i < D-1)) begin
        dl_r[i]  <= dl_r[(i < D-1) ? i+1 : i];
        tag_r[i] <= tag_r[(i < D-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.insert_en) begin
      cnt_r <= cnt_r + stq_pkg::CNT_W'(1);
    end else if (cmd.pop_en) begin
      cnt_r <= cnt_r - stq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res_status_r <= cmd.res_code;
      res_dl_r     <= cmd.pop_en ? dl_r[0] : '0;
      res_tag_r    <= cmd.pop_en ? stq_pkg::TAG_W'(tag_r[0]) : '0;
    end
  end

  assign out_status           = res_status_r;
  assign out_expired_deadline = res_dl_r;
  assign out_expired_tag      = res_tag_r;

  `STQ_NEVER(a_cnt_range, cnt_r > stq_pkg::CNT_W'(D), "entry count beyond depth")
  `STQ_ASSERT(a_cnt_inc, rst_n && cmd.insert_en |=> cnt_r == $past(cnt_r) + 1'b1, "insert count")
  `STQ_ASSERT(a_cnt_dec, rst_n && cmd.pop_en |=> cnt_r == $past(cnt_r) - 1'b1, "pop count")

endmodule

// ===== hdl/sorted_timer_queue.sv =====
// Top level: sorted timer queue, controller plus cell-chain datapath
`timescale 1ns / 1ps

// Sorted timer queue holding up to QUEUE_DEPTH timers ordered by deadline, equal
// deadlines in arrival order. Every item (insert or pop) is handled by a chain of
// compare-and-shift cells, so one item is taken per clock unless the input is
// stalled; the result sits in an output register, and the input stalls only while
// that result is itself stalled. Inserts into a full queue are dropped with status 1;
// a pop returns the head only when its deadline is not later than now_time.
module sorted_timer_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [stq_pkg::DL_W-1:0]       in_deadline,
  input  logic [stq_pkg::TAG_W-1:0]      in_timer_tag,
  input  logic [stq_pkg::DL_W-1:0]       in_now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stq_pkg::STAT_W-1:0]     out_status,
  output logic [stq_pkg::DL_W-1:0]       out_expired_deadline,
  output logic [stq_pkg::TAG_W-1:0]      out_expired_tag
);

  stq_pkg::stq_cmd_t cmd;
  stq_pkg::stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  stq_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_deadline          (in_deadline),
    .in_timer_tag         (in_timer_tag),
    .in_now_time          (in_now_time),
    .out_status           (out_status),
    .out_expired_deadline (out_expired_deadline),
    .out_expired_tag      (out_expired_tag)
  );

endmodule
